### src/adcd_pkg.sv
package adcd_pkg;

   localparam int MAX_CLASSES = 80;
   localparam int GRID_SIZE   = 256;
   localparam int FIFO_DEPTH  = 2;
   localparam int DIV_STEPS   = 33;

   localparam logic [2:0] CSR_CLASS_COUNT   = 3'd0;
   localparam logic [2:0] CSR_BOX_COUNT     = 3'd1;
   localparam logic [2:0] CSR_OBJ_COUNT     = 3'd2;
   localparam logic [2:0] CSR_GRID_STRIDE   = 3'd3;
   localparam logic [2:0] CSR_SCORE_THRESH  = 3'd4;
   localparam logic [2:0] CSR_OBJ_PREFILTER = 3'd5;
   localparam logic [2:0] CSR_ANCHOR_WIDTH  = 3'd6;
   localparam logic [2:0] CSR_ANCHOR_HEIGHT = 3'd7;

   typedef struct packed {
      logic [6:0]  class_count;
      logic [3:0]  box_channel_count;
      logic [1:0]  objectness_channel_count;
      logic [6:0]  grid_stride;
      logic [15:0] score_threshold;
      logic [15:0] objectness_prefilter;
      logic [15:0] anchor_width;
      logic [15:0] anchor_height;
   } cfg_type;

   typedef enum logic [1:0] {
      MATH_EXP,
      MATH_SIG,
      MATH_DIV
   } math_op_type;

   typedef struct packed {
      logic        start;
      math_op_type op;
      logic [15:0] arg;
      logic [32:0] num;
      logic [23:0] den;
   } math_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] result;
   } math_rsp_type;

   typedef struct packed {
      logic [15:0]       obj;
      logic [23:0]       sum;
      logic [6:0]        best;
      logic [3:0][15:0]  box;
      logic [7:0]        col;
      logic [7:0]        row;
   } cell_rec_type;

   typedef enum logic [2:0] {
      M_IDLE,
      M_EXP1,
      M_EXP2,
      M_PREP,
      M_DIV
   } math_state_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_SIG,
      F_SIG_WAIT,
      F_EXP,
      F_EXP_WAIT,
      F_MUL,
      F_END
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_CHECK,
      B_SCORE_WAIT,
      B_SIG,
      B_SIG_WAIT,
      B_MUL1,
      B_MUL2,
      B_EDGE,
      B_OUT
   } back_state_type;

   // exp(-i) for the integer part of the distance, Q1.16.
   function automatic logic [16:0] exp_int_lut(input logic [3:0] i);
      logic [16:0] v;
      unique case (i)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd24109;
         4'd2:    v = 17'd8869;
         4'd3:    v = 17'd3263;
         4'd4:    v = 17'd1200;
         4'd5:    v = 17'd442;
         4'd6:    v = 17'd162;
         4'd7:    v = 17'd60;
         4'd8:    v = 17'd22;
         4'd9:    v = 17'd8;
         4'd10:   v = 17'd3;
         4'd11:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] exp_hi_lut(input logic [3:0] i);
      logic [16:0] v;
      unique case (i)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd61565;
         4'd2:  v = 17'd57835;
         4'd3:  v = 17'd54331;
         4'd4:  v = 17'd51039;
         4'd5:  v = 17'd47947;
         4'd6:  v = 17'd45042;
         4'd7:  v = 17'd42313;
         4'd8:  v = 17'd39750;
         4'd9:  v = 17'd37341;
         4'd10: v = 17'd35079;
         4'd11: v = 17'd32954;
         4'd12: v = 17'd30957;
         4'd13: v = 17'd29081;
         4'd14: v = 17'd27319;
         4'd15: v = 17'd25664;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] exp_lo_lut(input logic [3:0] i);
      logic [16:0] v;
      unique case (i)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd65280;
         4'd2:  v = 17'd65026;
         4'd3:  v = 17'd64772;
         4'd4:  v = 17'd64520;
         4'd5:  v = 17'd64268;
         4'd6:  v = 17'd64018;
         4'd7:  v = 17'd63768;
         4'd8:  v = 17'd63520;
         4'd9:  v = 17'd63272;
         4'd10: v = 17'd63025;
         4'd11: v = 17'd62780;
         4'd12: v = 17'd62535;
         4'd13: v = 17'd62291;
         4'd14: v = 17'd62048;
         4'd15: v = 17'd61806;
      endcase
      return v;
   endfunction

endpackage

### src/adcd_req_if.sv
interface adcd_req_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] logit_value;
   logic [7:0]        cell_col;
   logic [7:0]        cell_row;

   modport source (output valid, logit_value, cell_col, cell_row, input ready);
   modport sink (input valid, logit_value, cell_col, cell_row, output ready);
endinterface

### src/adcd_rsp_if.sv
interface adcd_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [18:0] left_edge;
   logic signed [18:0] top_edge;
   logic signed [18:0] right_edge;
   logic signed [18:0] bottom_edge;
   logic [15:0]       confidence;
   logic [6:0]        class_label;

   modport source (output valid, left_edge, top_edge, right_edge, bottom_edge,
                   confidence, class_label, input ready);
   modport sink (input valid, left_edge, top_edge, right_edge, bottom_edge,
                 confidence, class_label, output ready);
endinterface

### src/adcd_math.sv
module adcd_math (
   input  logic                  clock,
   input  logic                  reset,
   input  adcd_pkg::math_req_type req,
   output adcd_pkg::math_rsp_type rsp
);
   import adcd_pkg::*;

   math_state_type state_ff, state_in;
   math_op_type    op_ff;
   logic           neg_ff;
   logic [15:0]    d_ff;
   logic           zero_ff;
   logic [16:0]    r1_ff;
   logic [32:0]    num_ff;
   logic [23:0]    den_ff;
   logic [23:0]    rem_ff;
   logic [5:0]     cnt_ff;
   logic           done_ff;
   logic [16:0]    result_ff;

   logic           sig_neg;
   logic [33:0]    p1;
   logic [33:0]    p2;
   logic [16:0]    e_val;
   logic [24:0]    rem_sh;
   logic           fits;
   logic [32:0]    quot;
   logic [16:0]    quot_sat;

   assign sig_neg = (req.op == MATH_SIG) && req.arg[15];

   // Three-table product for exp(-d): integer part, then the two fraction nibbles.
   assign p1    = 34'(exp_int_lut(d_ff[11:8])) * 34'(exp_hi_lut(d_ff[7:4]));
   assign p2    = 34'(r1_ff) * 34'(exp_lo_lut(d_ff[3:0]));
   assign e_val = zero_ff ? 17'd0 : 17'((p2 + 34'd32768) >> 16);

   // One restoring division step; the quotient shifts into the dividend register.
   assign rem_sh   = {rem_ff, num_ff[32]};
   assign fits     = rem_sh >= {1'b0, den_ff};
   assign quot     = {num_ff[31:0], fits};
   assign quot_sat = (|quot[32:16]) ? 17'd65535 : {1'b0, quot[15:0]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (req.start) state_in = (req.op == MATH_DIV) ? M_PREP : M_EXP1;
         end
         M_EXP1: state_in = M_EXP2;
         M_EXP2: state_in = (op_ff == MATH_EXP) ? M_IDLE : M_PREP;
         M_PREP: state_in = M_DIV;
         M_DIV: begin
            if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_comb begin
      rsp.done   = done_ff;
      rsp.result = result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= 1'b0;
         unique case (state_ff)
            M_EXP2: begin
               if (op_ff == MATH_EXP) done_ff <= 1'b1;
            end
            M_DIV: begin
               if (cnt_ff == 6'(DIV_STEPS - 1)) done_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               op_ff  <= req.op;
               neg_ff <= sig_neg;
               d_ff   <= sig_neg ? 16'(16'd0 - req.arg) : req.arg;
               num_ff <= req.num;
               den_ff <= req.den;
            end
         end
         M_EXP1: begin
            r1_ff   <= 17'((p1 + 34'd32768) >> 16);
            zero_ff <= d_ff[15:8] >= 8'd12;
         end
         M_EXP2: begin
            result_ff <= e_val;
            num_ff    <= neg_ff ? {e_val[16:0], 16'd0} : 33'h1_0000_0000;
            den_ff    <= 24'(24'd65536 + 24'(e_val));
         end
         M_PREP: begin
            // Rounding half up: add half the divisor before dividing.
            num_ff <= num_ff + 33'(den_ff >> 1);
            rem_ff <= 24'd0;
            cnt_ff <= 6'd0;
         end
         M_DIV: begin
            rem_ff <= fits ? 24'(rem_sh - {1'b0, den_ff}) : rem_sh[23:0];
            num_ff <= quot;
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) result_ff <= quot_sat;
         end
         default: ;
      endcase
   end

endmodule

### src/adcd_fifo.sv
module adcd_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  adcd_pkg::cell_rec_type push_rec,
   output logic                  push_full,
   input  logic                  pop,
   output logic                  pop_valid,
   output adcd_pkg::cell_rec_type pop_rec
);
   import adcd_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   cell_rec_type     mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff;
   logic [PTR_W-1:0] rd_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_full = count_ff == CNT_W'(FIFO_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_rec   = mem_ff[rd_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_rec;
   end

endmodule

### src/adcd_front.sv
module adcd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  adcd_pkg::cfg_type      cfg,
   adcd_req_if.sink               req_chan,
   output adcd_pkg::math_req_type math_req,
   input  adcd_pkg::math_rsp_type math_rsp,
   output logic                   push_valid,
   output adcd_pkg::cell_rec_type push_rec,
   input  logic                   push_full
);
   import adcd_pkg::*;

   front_state_type  state_ff, state_in;
   logic [6:0]       pos_ff;
   logic [15:0]      logit_ff;
   logic [7:0]       col_ff;
   logic [7:0]       row_ff;
   logic [3:0][15:0] box_ff;
   logic [15:0]      obj_ff;
   logic [15:0]      max_ff;
   logic [6:0]       best_ff;
   logic [23:0]      sum_ff;
   logic [16:0]      e_ff;
   logic [6:0]       c_ff;
   logic             greater_ff;
   logic             need_exp_ff;
   logic             last_ff;

   logic [3:0]  nbox;
   logic [6:0]  ncls_raw;
   logic [6:0]  ncls;
   logic [4:0]  cls_off;
   logic [7:0]  total;
   logic [7:0]  pos_next;
   logic        accept;
   logic        is_obj;
   logic        is_cls;
   logic [6:0]  cls_idx;
   logic        need_exp;
   logic [40:0] mul_prod;
   logic [40:0] mul_round;
   logic [23:0] mul_sum;
   logic [16:0] diff;

   assign nbox     = (cfg.box_channel_count < 4'd4) ? 4'd4 : cfg.box_channel_count;
   assign ncls_raw = (cfg.class_count == 7'd0) ? 7'd1 : cfg.class_count;
   assign ncls     = (ncls_raw > 7'(MAX_CLASSES)) ? 7'(MAX_CLASSES) : ncls_raw;
   assign cls_off  = 5'(nbox) + 5'(cfg.objectness_channel_count);
   assign total    = 8'(cls_off) + 8'(ncls);
   assign pos_next = 8'(pos_ff) + 8'd1;

   assign accept   = req_chan.valid && req_chan.ready;
   assign is_obj   = pos_ff == 7'(nbox);
   assign is_cls   = pos_ff >= 7'(cls_off);
   assign cls_idx  = 7'(pos_ff - 7'(cls_off));
   assign need_exp = is_cls && (cls_idx != 7'd0);

   // Rescale the running sum when a new maximum arrives, then add one for it.
   assign mul_prod  = 41'(sum_ff) * 41'(e_ff);
   assign mul_round = (mul_prod + 41'd32768) >> 16;
   assign mul_sum   = 24'(mul_round + 41'd65536);

   assign diff = greater_ff ? 17'($signed(logit_ff) - $signed(max_ff))
                            : 17'($signed(max_ff) - $signed(logit_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) state_in = is_obj ? F_SIG : (need_exp ? F_EXP : F_END);
         end
         F_SIG: state_in = F_SIG_WAIT;
         F_SIG_WAIT: begin
            if (math_rsp.done) state_in = need_exp_ff ? F_EXP : F_END;
         end
         F_EXP: state_in = F_EXP_WAIT;
         F_EXP_WAIT: begin
            if (math_rsp.done) state_in = greater_ff ? F_MUL : F_END;
         end
         F_MUL: state_in = F_END;
         F_END: begin
            if (!last_ff || !push_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = state_ff == F_IDLE;
      math_req.start = (state_ff == F_SIG) || (state_ff == F_EXP);
      math_req.op    = (state_ff == F_SIG) ? MATH_SIG : MATH_EXP;
      math_req.arg   = (state_ff == F_SIG) ? logit_ff : diff[15:0];
      math_req.num   = '0;
      math_req.den   = '0;
      push_valid     = (state_ff == F_END) && last_ff;
      push_rec.obj   = obj_ff;
      push_rec.sum   = sum_ff;
      push_rec.best  = best_ff;
      push_rec.box   = box_ff;
      push_rec.col   = col_ff;
      push_rec.row   = row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_ff   <= 7'd0;
         obj_ff   <= 16'd0;
         max_ff   <= 16'd0;
         best_ff  <= 7'd0;
         sum_ff   <= 24'd0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            F_IDLE: begin
               if (accept && is_cls && (cls_idx == 7'd0)) begin
                  max_ff  <= req_chan.logit_value;
                  best_ff <= 7'd0;
                  sum_ff  <= 24'd65536;
               end
            end
            F_SIG_WAIT: begin
               if (math_rsp.done) obj_ff <= math_rsp.result[15:0];
            end
            F_EXP_WAIT: begin
               if (math_rsp.done && !greater_ff) begin
                  sum_ff <= 24'(25'(sum_ff) + 25'(math_rsp.result));
               end
            end
            F_MUL: begin
               sum_ff  <= mul_sum;
               max_ff  <= logit_ff;
               best_ff <= c_ff;
            end
            F_END: begin
               if (!last_ff) begin
                  pos_ff <= 7'(pos_next);
               end else if (!push_full) begin
                  pos_ff <= 7'd0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         logit_ff    <= req_chan.logit_value;
         col_ff      <= (11'(req_chan.cell_col) >= 11'(GRID_SIZE)) ?
                        8'(GRID_SIZE - 1) : req_chan.cell_col;
         row_ff      <= (11'(req_chan.cell_row) >= 11'(GRID_SIZE)) ?
                        8'(GRID_SIZE - 1) : req_chan.cell_row;
         c_ff        <= cls_idx;
         greater_ff  <= $signed(req_chan.logit_value) > $signed(max_ff);
         need_exp_ff <= need_exp;
         last_ff     <= !(pos_next < total);
         if (pos_ff < 7'd4) box_ff[pos_ff[1:0]] <= req_chan.logit_value;
      end
      if ((state_ff == F_EXP_WAIT) && math_rsp.done) e_ff <= math_rsp.result;
   end

endmodule

### src/adcd_back.sv
module adcd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  adcd_pkg::cfg_type      cfg,
   input  logic                   pop_valid,
   input  adcd_pkg::cell_rec_type pop_rec,
   output logic                   pop,
   output adcd_pkg::math_req_type math_req,
   input  adcd_pkg::math_rsp_type math_rsp,
   adcd_rsp_if.source             rsp_chan
);
   import adcd_pkg::*;

   back_state_type   state_ff, state_in;
   cell_rec_type     rec_ff;
   logic [15:0]      score_ff;
   logic [1:0]       k_ff;
   logic [3:0][15:0] sig_ff;
   logic signed [33:0] cx_ff;
   logic signed [33:0] cy_ff;
   logic [33:0]      sqw_ff;
   logic [33:0]      sqh_ff;
   logic [48:0]      hw_ff;
   logic [48:0]      hh_ff;
   logic [18:0]      left_ff;
   logic [18:0]      top_ff;
   logic [18:0]      right_ff;
   logic [18:0]      bottom_ff;

   logic               pass;
   logic signed [25:0] ax;
   logic signed [25:0] ay;
   logic signed [7:0]  stride_s;
   logic [49:0]        hw_full;
   logic [49:0]        hh_full;
   logic signed [55:0] ce_x;
   logic signed [55:0] ce_y;
   logic signed [55:0] he_x;
   logic signed [55:0] he_y;

   // Round half up from 2^-36 to 2^-4 and clamp to the 19-bit signed range.
   function automatic logic [18:0] edge_round(input logic signed [55:0] v);
      logic signed [55:0] r;
      logic signed [23:0] q;
      logic [18:0]        o;
      r = v + 56'sd2147483648;
      q = r[55:32];
      if (q < -24'sd262144) begin
         o = 19'h40000;
      end else if (q > 24'sd262143) begin
         o = 19'h3FFFF;
      end else begin
         o = q[18:0];
      end
      return o;
   endfunction

   assign pass = (rec_ff.obj >= cfg.objectness_prefilter) &&
                 (math_rsp.result[15:0] >= cfg.score_threshold);

   assign stride_s = $signed({1'b0, cfg.grid_stride});
   assign ax = $signed({2'b0, rec_ff.col, 16'd0}) + $signed({9'd0, sig_ff[0], 1'b0})
               - 26'sd32768;
   assign ay = $signed({2'b0, rec_ff.row, 16'd0}) + $signed({9'd0, sig_ff[1], 1'b0})
               - 26'sd32768;

   assign hw_full = 50'(sqw_ff) * 50'(cfg.anchor_width);
   assign hh_full = 50'(sqh_ff) * 50'(cfg.anchor_height);

   assign ce_x = $signed({{2{cx_ff[33]}}, cx_ff, 20'd0});
   assign ce_y = $signed({{2{cy_ff[33]}}, cy_ff, 20'd0});
   assign he_x = $signed({7'd0, hw_ff});
   assign he_y = $signed({7'd0, hh_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) state_in = B_CHECK;
         end
         B_CHECK: state_in = (rec_ff.sum == 24'd0) ? B_IDLE : B_SCORE_WAIT;
         B_SCORE_WAIT: begin
            if (math_rsp.done) state_in = pass ? B_SIG : B_IDLE;
         end
         B_SIG: state_in = B_SIG_WAIT;
         B_SIG_WAIT: begin
            if (math_rsp.done) state_in = (k_ff == 2'd3) ? B_MUL1 : B_SIG;
         end
         B_MUL1: state_in = B_MUL2;
         B_MUL2: state_in = B_EDGE;
         B_EDGE: state_in = B_OUT;
         B_OUT: begin
            if (rsp_chan.ready) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop                  = (state_ff == B_IDLE) && pop_valid;
      math_req.start       = ((state_ff == B_CHECK) && (rec_ff.sum != 24'd0)) ||
                             (state_ff == B_SIG);
      math_req.op          = (state_ff == B_SIG) ? MATH_SIG : MATH_DIV;
      math_req.arg         = rec_ff.box[k_ff];
      math_req.num         = {1'b0, rec_ff.obj, 16'd0};
      math_req.den         = rec_ff.sum;
      rsp_chan.valid       = state_ff == B_OUT;
      rsp_chan.left_edge   = $signed(left_ff);
      rsp_chan.top_edge    = $signed(top_ff);
      rsp_chan.right_edge  = $signed(right_ff);
      rsp_chan.bottom_edge = $signed(bottom_ff);
      rsp_chan.confidence  = score_ff;
      rsp_chan.class_label = rec_ff.best;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) rec_ff <= pop_rec;
         end
         B_SCORE_WAIT: begin
            score_ff <= math_rsp.result[15:0];
            k_ff     <= 2'd0;
         end
         B_SIG_WAIT: begin
            if (math_rsp.done) begin
               sig_ff[k_ff] <= math_rsp.result[15:0];
               k_ff         <= k_ff + 2'd1;
            end
         end
         B_MUL1: begin
            cx_ff  <= 34'(ax) * 34'(stride_s);
            cy_ff  <= 34'(ay) * 34'(stride_s);
            sqw_ff <= 34'({sig_ff[2], 1'b0}) * 34'({sig_ff[2], 1'b0});
            sqh_ff <= 34'({sig_ff[3], 1'b0}) * 34'({sig_ff[3], 1'b0});
         end
         B_MUL2: begin
            hw_ff <= hw_full[49:1];
            hh_ff <= hh_full[49:1];
         end
         B_EDGE: begin
            left_ff   <= edge_round(ce_x - he_x);
            top_ff    <= edge_round(ce_y - he_y);
            right_ff  <= edge_round(ce_x + he_x);
            bottom_ff <= edge_round(ce_y + he_y);
         end
         default: ;
      endcase
   end

endmodule

### src/anchor_detection_cell_decode_top.sv
// Channel   Modport  Word
// req_chan  sink     logit_value (s16 Q8.8), cell_col (u8), cell_row (u8)
// rsp_chan  source   left/top/right/bottom_edge (s19 Q15.4), confidence (u16),
//                    class_label (u7)
// csr_*     write    csr_write_enable, csr_index (3), csr_write_data (16)
//
// A box or first class channel needs no math unit; a further class channel walks
// the exp tables, then does the rescale multiply on a new maximum; the objectness
// channel waits on the front unit's sigmoid, which ends in a bit-per-cycle divider.
// The back unit divides for the score of each cell with a nonzero sum, then forms
// the four box sigmoids of each passing cell, again through its own divider.
// Reset is synchronous and returns the configuration to its defaults.
// A two-cell queue parts the front from the back; a stalled result holds the
// back, and the front keeps taking words until the queue is full.
module anchor_detection_cell_decode_top (
   input  logic        clock,
   input  logic        reset,
   adcd_req_if.sink    req_chan,
   adcd_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import adcd_pkg::*;

   cfg_type      cfg_ff;
   math_req_type front_math_req;
   math_rsp_type front_math_rsp;
   math_req_type back_math_req;
   math_rsp_type back_math_rsp;
   logic         push_valid;
   logic         push_full;
   cell_rec_type push_rec;
   logic         pop;
   logic         pop_valid;
   cell_rec_type pop_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.class_count              <= 7'd1;
         cfg_ff.box_channel_count        <= 4'd4;
         cfg_ff.objectness_channel_count <= 2'd1;
         cfg_ff.grid_stride              <= 7'd8;
         cfg_ff.score_threshold          <= 16'd16384;
         cfg_ff.objectness_prefilter     <= 16'd3277;
         cfg_ff.anchor_width             <= 16'd0;
         cfg_ff.anchor_height            <= 16'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CLASS_COUNT:   cfg_ff.class_count <= csr_write_data[6:0];
            CSR_BOX_COUNT:     cfg_ff.box_channel_count <= csr_write_data[3:0];
            CSR_OBJ_COUNT:     cfg_ff.objectness_channel_count <= csr_write_data[1:0];
            CSR_GRID_STRIDE:   cfg_ff.grid_stride <= csr_write_data[6:0];
            CSR_SCORE_THRESH:  cfg_ff.score_threshold <= csr_write_data;
            CSR_OBJ_PREFILTER: cfg_ff.objectness_prefilter <= csr_write_data;
            CSR_ANCHOR_WIDTH:  cfg_ff.anchor_width <= csr_write_data;
            CSR_ANCHOR_HEIGHT: cfg_ff.anchor_height <= csr_write_data;
         endcase
      end
   end

   adcd_math u_front_math (
      .clock (clock),
      .reset (reset),
      .req   (front_math_req),
      .rsp   (front_math_rsp)
   );

   adcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .math_req   (front_math_req),
      .math_rsp   (front_math_rsp),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .push_full  (push_full)
   );

   adcd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .push_full  (push_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_rec    (pop_rec)
   );

   adcd_math u_back_math (
      .clock (clock),
      .reset (reset),
      .req   (back_math_req),
      .rsp   (back_math_rsp)
   );

   adcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_rec   (pop_rec),
      .pop       (pop),
      .math_req  (back_math_req),
      .math_rsp  (back_math_rsp),
      .rsp_chan  (rsp_chan)
   );

endmodule

### dv/tb_anchor_detection_cell_decode_top.sv
`timescale 1ns / 1ps

module tb_anchor_detection_cell_decode_top;
   import adcd_pkg::*;

   typedef struct packed {
      logic signed [18:0] left_edge;
      logic signed [18:0] top_edge;
      logic signed [18:0] right_edge;
      logic signed [18:0] bottom_edge;
      logic [15:0]        confidence;
      logic [6:0]         class_label;
   } proposal_type;

   class cell_decode_model;
      int unsigned exp_whole[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
      int unsigned exp_frac_hi[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                       42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                       27319, 25664};
      int unsigned exp_frac_lo[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                                       63768, 63520, 63272, 63025, 62780, 62535, 62291,
                                       62048, 61806};
      cfg_type     cfg;
      int unsigned position;
      int          box_word[4];
      int unsigned obj_prob;
      int          peak_logit;
      int unsigned best_class;
      int unsigned exp_sum;
      proposal_type pending_proposals[$];
      int          mismatches;

      function void clear();
         cfg.class_count = 1;
         cfg.box_channel_count = 4;
         cfg.objectness_channel_count = 1;
         cfg.grid_stride = 8;
         cfg.score_threshold = 16384;
         cfg.objectness_prefilter = 3277;
         cfg.anchor_width = 0;
         cfg.anchor_height = 0;
         position = 0;
         foreach (box_word[i]) box_word[i] = 0;
         obj_prob = 0;
         peak_logit = 0;
         best_class = 0;
         exp_sum = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            CSR_CLASS_COUNT:   cfg.class_count = v[6:0];
            CSR_BOX_COUNT:     cfg.box_channel_count = v[3:0];
            CSR_OBJ_COUNT:     cfg.objectness_channel_count = v[1:0];
            CSR_GRID_STRIDE:   cfg.grid_stride = v[6:0];
            CSR_SCORE_THRESH:  cfg.score_threshold = v;
            CSR_OBJ_PREFILTER: cfg.objectness_prefilter = v;
            CSR_ANCHOR_WIDTH:  cfg.anchor_width = v;
            CSR_ANCHOR_HEIGHT: cfg.anchor_height = v;
            default: ;
         endcase
      endfunction

      function int unsigned exp_neg(int unsigned d);
         longint unsigned r;
         if ((d >> 8) >= 12) return 0;
         r = (longint'(exp_whole[d >> 8]) * exp_frac_hi[(d >> 4) & 15] + 32768) >> 16;
         r = (r * exp_frac_lo[d & 15] + 32768) >> 16;
         return int'(r);
      endfunction

      function int unsigned sigmoid(int x);
         longint unsigned e, den, num, s;
         e = exp_neg(x < 0 ? -x : x);
         den = 65536 + e;
         num = x < 0 ? (e << 16) : 64'h1_0000_0000;
         s = (num + den / 2) / den;
         return s > 65535 ? 65535 : int'(s);
      endfunction

      function logic signed [18:0] edge_q(longint v);
         longint q;
         q = (v + (64'sd1 <<< 31)) >>> 32;
         if (q < -262144) q = -262144;
         if (q > 262143) q = 262143;
         return q[18:0];
      endfunction

      function int unsigned cell_length();
         int unsigned nbox, ncls;
         nbox = cfg.box_channel_count < 4 ? 4 : cfg.box_channel_count;
         ncls = cfg.class_count == 0 ? 1 : cfg.class_count;
         if (ncls > MAX_CLASSES) ncls = MAX_CLASSES;
         return nbox + cfg.objectness_channel_count + ncls;
      endfunction

      function void note_word(logic signed [15:0] word, logic [7:0] col, logic [7:0] row);
         int logit;
         int unsigned nbox, cls_off, score, sx, sy, sw, sh;
         longint unsigned s, sq;
         longint cx, cy, hw, hh;
         proposal_type p;
         logit = word;
         nbox = cfg.box_channel_count < 4 ? 4 : cfg.box_channel_count;
         cls_off = nbox + cfg.objectness_channel_count;
         if (position < 4) box_word[position] = logit;
         if (position == nbox) obj_prob = sigmoid(logit);
         if (position >= cls_off) begin
            if (position == cls_off) begin
               peak_logit = logit;
               best_class = 0;
               exp_sum = 65536;
            end else if (logit > peak_logit) begin
               s = ((longint'(exp_sum) * exp_neg(logit - peak_logit) + 32768) >> 16) + 65536;
               exp_sum = int'(s & 24'hFFFFFF);
               peak_logit = logit;
               best_class = (position - cls_off) & 7'h7F;
            end else begin
               s = longint'(exp_sum) + exp_neg(peak_logit - logit);
               exp_sum = int'(s & 24'hFFFFFF);
            end
         end
         if (position + 1 < cell_length()) begin
            position++;
            return;
         end
         position = 0;
         if (exp_sum == 0) return;
         s = ((longint'(obj_prob) << 16) + exp_sum / 2) / exp_sum;
         score = s > 65535 ? 65535 : int'(s);
         if (obj_prob < cfg.objectness_prefilter || score < cfg.score_threshold) return;
         sx = sigmoid(box_word[0]);
         sy = sigmoid(box_word[1]);
         sw = sigmoid(box_word[2]);
         sh = sigmoid(box_word[3]);
         cx = (2 * longint'(sx) - 32768 + longint'(col) * 65536) * cfg.grid_stride * 1048576;
         cy = (2 * longint'(sy) - 32768 + longint'(row) * 65536) * cfg.grid_stride * 1048576;
         sq = longint'(2 * sw) * longint'(2 * sw);
         hw = longint'((sq * cfg.anchor_width) >> 1);
         sq = longint'(2 * sh) * longint'(2 * sh);
         hh = longint'((sq * cfg.anchor_height) >> 1);
         p.left_edge = edge_q(cx - hw);
         p.top_edge = edge_q(cy - hh);
         p.right_edge = edge_q(cx + hw);
         p.bottom_edge = edge_q(cy + hh);
         p.confidence = score[15:0];
         p.class_label = best_class[6:0];
         pending_proposals.insert(pending_proposals.size(), p);
      endfunction

      task flag_mismatch(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_proposal(proposal_type got);
         proposal_type want;
         if (pending_proposals.size() == 0) begin
            flag_mismatch($sformatf("unexpected proposal %p", got));
            return;
         end
         want = pending_proposals.pop_front();
         if (got.left_edge !== want.left_edge)
            flag_mismatch($sformatf("left_edge %0d, want %0d", got.left_edge, want.left_edge));
         if (got.top_edge !== want.top_edge)
            flag_mismatch($sformatf("top_edge %0d, want %0d", got.top_edge, want.top_edge));
         if (got.right_edge !== want.right_edge)
            flag_mismatch($sformatf("right_edge %0d, want %0d", got.right_edge,
                                    want.right_edge));
         if (got.bottom_edge !== want.bottom_edge)
            flag_mismatch($sformatf("bottom_edge %0d, want %0d", got.bottom_edge,
                                    want.bottom_edge));
         if (got.confidence !== want.confidence)
            flag_mismatch($sformatf("confidence %0d, want %0d", got.confidence,
                                    want.confidence));
         if (got.class_label !== want.class_label)
            flag_mismatch($sformatf("class_label %0d, want %0d", got.class_label,
                                    want.class_label));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [15:0] csr_write_data;

   adcd_req_if req_chan();
   adcd_rsp_if rsp_chan();

   anchor_detection_cell_decode_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cell_decode_model model = new();
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          hold_request;
   int          hold_seen;
   int          hold_left;
   int          words_sent;

   always #5 clock = ~clock;

   // Receiver side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= 3000;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= $urandom_range(0, 99) >= receiver_stall_pct;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         model.check_proposal('{rsp_chan.left_edge, rsp_chan.top_edge, rsp_chan.right_edge,
                                rsp_chan.bottom_edge, rsp_chan.confidence,
                                rsp_chan.class_label});
   end

   task send_word(logic signed [15:0] v, logic [7:0] col, logic [7:0] row);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.logit_value <= v;
      req_chan.cell_col <= col;
      req_chan.cell_row <= row;
      do @(posedge clock); while (!req_chan.ready);
      model.note_word(v, col, row);
      words_sent++;
   endtask

   task settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (model.pending_proposals.size() != 0) @(posedge clock);
      // Cells that make no proposal may still be in the back unit.
      repeat (400) @(posedge clock);
   endtask

   task write_reg(logic [2:0] idx, logic [15:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model.set_reg(idx, v);
   endtask

   function logic signed [15:0] any_logit();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return 16'($urandom);
         default: return 16'($urandom_range(0, 4095)) - 16'sd2048;
      endcase
   endfunction

   // A well-formed cell leans towards a confident objectness and one
   // dominant class so that a good share of cells produces a proposal.
   task send_cell(bit noisy);
      int unsigned len, nbox, cls_off, winner;
      logic [7:0] col, row;
      logic signed [15:0] v;
      len = model.cell_length();
      nbox = model.cfg.box_channel_count < 4 ? 4 : model.cfg.box_channel_count;
      cls_off = nbox + model.cfg.objectness_channel_count;
      winner = $urandom_range(0, len - cls_off - 1);
      col = $urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom);
      row = $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom);
      for (int p = 0; p < len; p++) begin
         v = any_logit();
         if (!noisy && p == nbox) v = 16'($urandom_range(256, 3072));
         else if (!noisy && p == cls_off + winner) v = 16'($urandom_range(1024, 2560));
         else if (!noisy && p >= cls_off) v = 16'($urandom_range(0, 1024)) - 16'sd512;
         if (noisy && $urandom_range(0, 3) == 0) begin
            col = 8'($urandom);
            row = 8'($urandom);
         end
         send_word(v, col, row);
      end
   endtask

   task configure(logic [15:0] v[8]);
      write_reg(CSR_CLASS_COUNT, v[0]);
      write_reg(CSR_BOX_COUNT, v[1]);
      write_reg(CSR_OBJ_COUNT, v[2]);
      write_reg(CSR_GRID_STRIDE, v[3]);
      write_reg(CSR_SCORE_THRESH, v[4]);
      write_reg(CSR_OBJ_PREFILTER, v[5]);
      write_reg(CSR_ANCHOR_WIDTH, v[6]);
      write_reg(CSR_ANCHOR_HEIGHT, v[7]);
   endtask

   initial begin
      logic [15:0] setting[8];
      int budget;
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_CLASS_COUNT;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.logit_value = '0;
      req_chan.cell_col = '0;
      req_chan.cell_row = '0;
      rsp_chan.ready = 1'b0;
      hold_request = 0;
      hold_seen = 0;
      hold_left = 0;
      words_sent = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      model.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of every field under the reset settings.
      for (int p = 0; p < 6; p++) send_word(16'sh7FFF, 8'hFF, 8'hFF);
      for (int p = 0; p < 6; p++) send_word(16'sh8000, 8'h00, 8'h00);
      settle();
      setting = '{16'd3, 16'd4, 16'd1, 16'd64, 16'd0, 16'd0, 16'd800, 16'd800};
      configure(setting);
      // Tied class logits: the first of them wins.
      for (int p = 0; p < 5; p++) send_word(p == 4 ? 16'sd2000 : -16'sd300, 8'd3, 8'd7);
      for (int p = 0; p < 3; p++) send_word(16'sd500, 8'd3, 8'd7);
      // Settings changed part way through a cell.
      for (int p = 0; p < 3; p++) send_word(16'sd100, 8'd9, 8'd9);
      settle();
      write_reg(CSR_CLASS_COUNT, 16'd1);
      for (int p = 0; p < 4; p++) send_word(16'sd700, 8'd10, 8'd11);
      settle();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: setting = '{16'd1, 16'd4, 16'd1, 16'd8, 16'd16384, 16'd3277, 16'd160, 16'd320};
            1: setting = '{16'd80, 16'd15, 16'd3, 16'd64, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
            2: setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
            3: setting = '{16'd127, 16'd3, 16'd2, 16'd1, 16'd1000, 16'd1000, 16'd100, 16'd50};
            4: setting = '{16'd2, 16'd4, 16'd1, 16'd32, 16'd0, 16'd0, 16'd400, 16'd400};
            default: setting = '{16'($urandom_range(1, 12)), 16'($urandom_range(0, 6)),
                                 16'($urandom_range(0, 3)), 16'($urandom_range(0, 64)),
                                 16'($urandom_range(0, 20000)), 16'($urandom_range(0, 30000)),
                                 16'($urandom), 16'($urandom)};
         endcase
         configure(setting);
         sender_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? (phase % 4 == 1 ? 50 : 27) : 0;
         receiver_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? (phase % 4 == 2 ? 50 : 27) : 0;
         // Long receiver hold-off while every cell passes: the cell queue fills.
         if (phase == 4) hold_request++;
         budget = words_sent + 90;
         while (words_sent < budget) send_cell($urandom_range(0, 5) == 0);
         settle();
      end

      if (model.pending_proposals.size() != 0)
         model.flag_mismatch($sformatf("%0d proposals never arrived",
                                       model.pending_proposals.size()));
      if (model.mismatches == 0)
         $display("tb_anchor_detection_cell_decode_top: done, clean");
      else
         $display("tb_anchor_detection_cell_decode_top: done, errors");
      $finish;
   end

   initial begin
      #8ms;
      $display("tb_anchor_detection_cell_decode_top: done, errors");
      $finish;
   end

endmodule

### filelist.f
src/adcd_pkg.sv
src/adcd_req_if.sv
src/adcd_rsp_if.sv
src/adcd_math.sv
src/adcd_fifo.sv
src/adcd_front.sv
src/adcd_back.sv
src/anchor_detection_cell_decode_top.sv
dv/tb_anchor_detection_cell_decode_top.sv
